// ===== sv/sbf_pkg.sv =====
// Shared constants and types for the section block framer.
`default_nettype none

package sbf_pkg;

    localparam int BLOCK_BYTES = 488;

    // Width of a block length (0 .. BLOCK_BYTES) and of a store address.
    localparam int BLEN_W = $clog2(BLOCK_BYTES + 1);
    localparam int RAM_AW = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;

    localparam int LEN_W  = 24;
    localparam int ADDR_W = 32;

    // Input commands carried on tuser.
    localparam logic CMD_DATA  = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    // Configuration register indexes.
    localparam logic REG_ADDRESS = 1'b0;
    localparam logic REG_LENGTH  = 1'b1;

    // Frame header constants. The tag "WLAN" is stored with its first
    // character in the lowest byte.
    localparam logic [31:0] TAG_WLAN   = 32'h4E41_4C57;
    localparam logic [15:0] TYPE_BLOCK = 16'h0200;
    localparam logic [15:0] TYPE_FINAL = 16'h0204;
    localparam logic [7:0]  SUB_BLOCK  = 8'h02;
    localparam logic [7:0]  SUB_FINAL  = 8'h03;
    localparam logic [15:0] HLEN_BLOCK = 16'd12;
    localparam logic [15:0] HLEN_FINAL = 16'd16;

    // Index of the last byte sent for a header request.
    localparam logic [4:0] FIRST_LAST_CNT = 5'd20;
    localparam logic [4:0] FINAL_LAST_CNT = 5'd23;

    typedef enum logic [1:0] {
        JOB_DATA,
        JOB_FIRST,
        JOB_FINAL,
        JOB_DRAIN
    } job_kind_t;

endpackage

`default_nettype wire

// ===== sv/section_block_framer_unit.sv =====
// Section block framer: cuts a memory section into framed download packets.
//
// The slave channel takes one request per beat: tuser = 0 carries a section
// data byte in tdata, tuser = 1 is a drain tick. The master channel sends the
// framed stream one byte per beat, with tlast on the last byte of each frame
// and tuser high on the last byte of the section's final frame.
// Every block but the last is sent as it arrives; its 20-byte header goes
// out with the block's first byte, and that request holds the input until
// the last of them is sent. The last block is written to a 488-byte store;
// its section's last byte releases the 24-byte final header, and each later
// drain tick reads one stored byte (one store read per tick) and sends it.
// A request's bytes pass through the job stage and then the output register
// to the master side. Ordinary data bytes and drain ticks sustain one per
// cycle while the receiver is ready; the single header sequencer sets the
// stall during header bursts. Requests that produce nothing are absorbed
// outside the job stage. Writing either configuration register starts a
// new section; the user must write only while the block is idle (unenforced).
// Reset clears all counters and the output register; the store needs no
// clearing because only entries written in the current section are read.
// When the receiver stalls, the output register holds its byte, one more
// request may be taken into the job stage, and then the input stalls too.
`default_nettype none

module section_block_framer_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,    // [7:0] data_byte
    input  wire logic        s_tuser,    // [0] command
    // output stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [7:0]  m_tdata,    // [7:0] out_byte
    output logic             m_tlast,
    output logic             m_tuser,    // [0] section_end
    // configuration
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_wdata
);

    localparam int BW = sbf_pkg::BLEN_W;
    localparam int LW = sbf_pkg::LEN_W;
    localparam int AW = sbf_pkg::RAM_AW;
    localparam logic [BW-1:0] BLOCK_B = BW'(sbf_pkg::BLOCK_BYTES);
    localparam logic [LW-1:0] BLOCK_L = LW'(sbf_pkg::BLOCK_BYTES);

    // Configuration
    logic [sbf_pkg::ADDR_W-1:0] addr_reg, addr_next;
    logic [LW-1:0]              len_reg, len_next;

    // Section state
    logic [LW-1:0] taken_reg, taken_next;
    logic [LW-1:0] off_reg, off_next;
    logic [LW-1:0] rem_reg, rem_next;      // len minus current block offset
    logic [BW-1:0] pos_reg, pos_next;
    logic [15:0]   xor_reg, xor_next;
    logic [7:0]    held_reg, held_next;
    logic          drain_active_reg, drain_active_next;
    logic [BW-1:0] drain_idx_reg, drain_idx_next;
    logic [BW-1:0] drain_blen_reg, drain_blen_next;

    // Job stage
    logic                job_valid_reg, job_valid_next;
    sbf_pkg::job_kind_t  job_kind_reg, job_kind_next;
    logic [4:0]          job_cnt_reg, job_cnt_next;
    logic [7:0]          job_data_reg, job_data_next;
    logic                job_fe_reg, job_fe_next;
    logic [LW-1:0]       job_off_reg, job_off_next;
    logic [BW-1:0]       job_blen_reg, job_blen_next;
    logic [15:0]         job_xor_reg, job_xor_next;

    // Output register
    logic       m_valid_reg, m_valid_next;
    logic [7:0] m_data_reg, m_data_next;
    logic       m_last_reg, m_last_next;
    logic       m_user_reg, m_user_next;

    // Store port
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic          ram_re;
    logic [7:0]    ram_rdata;

    logic          accept;
    logic          out_load;
    logic          job_done;
    logic [4:0]    last_cnt;
    logic          last_blk;
    logic [BW-1:0] blen;
    logic [191:0]  hdr_vec;
    logic [15:0]   blen16;
    logic [7:0]    sel_byte;
    logic          sel_last;

    sbf_ram #(
        .WIDTH (8),
        .DEPTH (sbf_pkg::BLOCK_BYTES)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s_tdata),
        .re    (ram_re),
        .raddr (drain_idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // ---------------------------------------------------------------
    // Emitter: walks the job stage one byte per cycle into the output while the output register can load.
    // ---------------------------------------------------------------
    assign out_load = !m_valid_reg || m_tready;

    always_comb begin
        case (job_kind_reg)
            sbf_pkg::JOB_FIRST: last_cnt = sbf_pkg::FIRST_LAST_CNT;
            sbf_pkg::JOB_FINAL: last_cnt = sbf_pkg::FINAL_LAST_CNT;
            default:            last_cnt = 5'd0;
        endcase
    end

    assign job_done = job_valid_reg && out_load && (job_cnt_reg == last_cnt);
    assign s_tready = !job_valid_reg || job_done;
    assign accept   = s_tvalid && s_tready;

    assign blen16 = 16'(job_blen_reg);

    always_comb begin
        if (job_kind_reg == sbf_pkg::JOB_FINAL) begin
            hdr_vec = {24'd0, blen16, 8'd0, job_off_reg, job_xor_reg, addr_reg,
                       sbf_pkg::SUB_FINAL, sbf_pkg::TYPE_FINAL,
                       sbf_pkg::HLEN_FINAL + blen16, sbf_pkg::TAG_WLAN};
        end else begin
            hdr_vec = {24'd0, job_data_reg, 8'd0, blen16, 8'd0, job_off_reg, addr_reg,
                       sbf_pkg::SUB_BLOCK, sbf_pkg::TYPE_BLOCK,
                       sbf_pkg::HLEN_BLOCK + blen16, sbf_pkg::TAG_WLAN};
        end
    end

    always_comb begin
        case (job_kind_reg)
            sbf_pkg::JOB_DATA:  sel_byte = job_data_reg;
            sbf_pkg::JOB_DRAIN: sel_byte = ram_rdata;
            default:            sel_byte = hdr_vec[8*job_cnt_reg +: 8];
        endcase
        sel_last = job_fe_reg && (job_cnt_reg == last_cnt);
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        m_user_next  = m_user_reg;
        if (out_load) begin
            m_valid_next = job_valid_reg;
            m_data_next  = sel_byte;
            m_last_next  = sel_last;
            m_user_next  = sel_last && (job_kind_reg == sbf_pkg::JOB_DRAIN);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

    // ---------------------------------------------------------------
    // Request decode and section state update.
    // ---------------------------------------------------------------
    assign last_blk  = (rem_reg <= BLOCK_L);
    assign blen      = last_blk ? rem_reg[BW-1:0] : BLOCK_B;
    assign ram_waddr = pos_reg[AW-1:0];

    always_comb begin
        addr_next         = addr_reg;
        len_next          = len_reg;
        taken_next        = taken_reg;
        off_next          = off_reg;
        rem_next          = rem_reg;
        pos_next          = pos_reg;
        xor_next          = xor_reg;
        held_next         = held_reg;
        drain_active_next = drain_active_reg;
        drain_idx_next    = drain_idx_reg;
        drain_blen_next   = drain_blen_reg;

        job_valid_next = job_done ? 1'b0 : job_valid_reg;
        job_kind_next  = job_kind_reg;
        job_cnt_next   = (job_valid_reg && out_load) ? job_cnt_reg + 5'd1 : job_cnt_reg;
        job_data_next  = job_data_reg;
        job_fe_next    = job_fe_reg;
        job_off_next   = job_off_reg;
        job_blen_next  = job_blen_reg;
        job_xor_next   = job_xor_reg;

        ram_we = 1'b0;
        ram_re = 1'b0;

        if (accept) begin
            job_cnt_next  = 5'd0;
            job_data_next = s_tdata;
            job_off_next  = off_reg;
            job_blen_next = blen;
            if (s_tuser == sbf_pkg::CMD_DRAIN) begin
                if (drain_active_reg && (drain_idx_reg < drain_blen_reg)) begin
                    ram_re         = 1'b1;
                    job_valid_next = 1'b1;
                    job_kind_next  = sbf_pkg::JOB_DRAIN;
                    job_fe_next    = (drain_idx_reg + BW'(1) >= drain_blen_reg);
                    if (job_fe_next) begin
                        drain_active_next = 1'b0;
                    end else begin
                        drain_idx_next = drain_idx_reg + BW'(1);
                    end
                end else begin
                    drain_active_next = 1'b0;
                end
            end else if (!drain_active_reg && (taken_reg < len_reg)) begin
                if (!taken_reg[0]) begin
                    held_next = s_tdata;
                end else begin
                    xor_next = xor_reg ^ {s_tdata, held_reg};
                end
                taken_next = taken_reg + LW'(1);
                if (pos_reg + BW'(1) == BLOCK_B) begin
                    pos_next = '0;
                    off_next = off_reg + BLOCK_L;
                    rem_next = rem_reg - BLOCK_L;
                end else begin
                    pos_next = pos_reg + BW'(1);
                end
                if (last_blk) begin
                    ram_we = 1'b1;
                    // The section's last byte releases the final header.
                    if (taken_reg + LW'(1) == len_reg) begin
                        job_valid_next    = 1'b1;
                        job_kind_next     = sbf_pkg::JOB_FINAL;
                        job_fe_next       = 1'b0;
                        job_xor_next      = xor_next;
                        drain_active_next = 1'b1;
                        drain_idx_next    = '0;
                        drain_blen_next   = blen;
                    end
                end else begin
                    job_valid_next = 1'b1;
                    job_kind_next  = (pos_reg == '0) ? sbf_pkg::JOB_FIRST : sbf_pkg::JOB_DATA;
                    job_fe_next    = (pos_reg + BW'(1) == blen);
                end
            end
        end

        if (cfg_we) begin
            if (cfg_index == sbf_pkg::REG_ADDRESS) begin
                addr_next = cfg_wdata;
            end else begin
                len_next = cfg_wdata[LW-1:0];
            end
            taken_next        = '0;
            off_next          = '0;
            rem_next          = len_next;
            pos_next          = '0;
            xor_next          = '0;
            held_next         = '0;
            drain_active_next = 1'b0;
            drain_idx_next    = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg         <= '0;
            len_reg          <= '0;
            taken_reg        <= '0;
            off_reg          <= '0;
            rem_reg          <= '0;
            pos_reg          <= '0;
            xor_reg          <= '0;
            held_reg         <= '0;
            drain_active_reg <= 1'b0;
            drain_idx_reg    <= '0;
            drain_blen_reg   <= '0;
            job_valid_reg    <= 1'b0;
            job_cnt_reg      <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            addr_reg         <= addr_next;
            len_reg          <= len_next;
            taken_reg        <= taken_next;
            off_reg          <= off_next;
            rem_reg          <= rem_next;
            pos_reg          <= pos_next;
            xor_reg          <= xor_next;
            held_reg         <= held_next;
            drain_active_reg <= drain_active_next;
            drain_idx_reg    <= drain_idx_next;
            drain_blen_reg   <= drain_blen_next;
            job_valid_reg    <= job_valid_next;
            job_cnt_reg      <= job_cnt_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        job_kind_reg <= job_kind_next;
        job_data_reg <= job_data_next;
        job_fe_reg   <= job_fe_next;
        job_off_reg  <= job_off_next;
        job_blen_reg <= job_blen_next;
        job_xor_reg  <= job_xor_next;
        m_data_reg   <= m_data_next;
        m_last_reg   <= m_last_next;
        m_user_reg   <= m_user_next;
    end

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_job_held : assert property (@(posedge aclk) disable iff (!aresetn)
        (job_valid_reg && !job_done) |=> (job_valid_reg && $stable(job_kind_reg)))
        else $error("job stage overwritten before its last byte was sent");

    a_drain_after_section : assert property (@(posedge aclk) disable iff (!aresetn)
        drain_active_reg |-> (taken_reg == len_reg))
        else $error("drain pending before the section was complete");

    a_drain_in_range : assert property (@(posedge aclk) disable iff (!aresetn)
        drain_active_reg |-> (drain_idx_reg < drain_blen_reg))
        else $error("drain index beyond the final block");

    a_no_store_write_in_drain : assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> !drain_active_reg)
        else $error("store written while a drain is pending");

    a_drain_reads_store : assert property (@(posedge aclk) disable iff (!aresetn)
        ram_re |=> (job_valid_reg && (job_kind_reg == sbf_pkg::JOB_DRAIN)))
        else $error("store read without a drain request in the job stage");

endmodule

`default_nettype wire

// ===== sv/sbf_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module sbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                      aclk,
    input  wire logic                                      we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                          wdata,
    input  wire logic                                      re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== test/tb_section_block_framer_unit.sv =====
// Self-checking testbench for the section block framer, with a byte-exact framing predictor.
`default_nettype none

module tb_section_block_framer_unit;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int TAIL_CYCLES  = 10;
    localparam int RANDOM_GOAL  = 80;

    localparam logic [31:0] FRAME_TAG  = "WLAN";
    localparam logic [15:0] KIND_BLOCK = 16'h0200;
    localparam logic [15:0] KIND_FINAL = 16'h0204;
    localparam logic [7:0]  MARK_BLOCK = 8'h02;
    localparam logic [7:0]  MARK_FINAL = 8'h03;
    localparam int          HDR_BLOCK  = 12;
    localparam int          HDR_FINAL  = 16;

    typedef enum int {
        WRITE_BOTH,
        WRITE_LENGTH_FIRST,
        WRITE_LENGTH_ONLY,
        WRITE_ADDRESS_ONLY
    } write_plan_t;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data;
    } request_t;

    typedef struct packed {
        logic [7:0] value;
        logic       frame_end;
        logic       section_end;
    } beat_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;
    logic        s_tuser   = sbf_pkg::CMD_DATA;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        m_tuser;
    logic        cfg_we    = 1'b0;
    logic        cfg_index = sbf_pkg::REG_ADDRESS;
    logic [31:0] cfg_wdata = 32'h0;

    section_block_framer_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Framer state as the testbench sees it.
    logic [31:0] sec_address = 32'h0;
    int unsigned sec_length  = 0;
    int unsigned taken       = 0;
    logic [15:0] pair_xor    = 16'h0;
    logic [7:0]  low_half    = 8'h0;
    logic [7:0]  tail_store [sbf_pkg::BLOCK_BYTES];
    int unsigned drain_pos   = 0;
    bit          drain_pending = 1'b0;

    request_t    requests_waiting [$];
    beat_t       beats_due [$];
    int          errors      = 0;
    int          cycle_count = 0;
    int          beats_seen  = 0;
    int          hold_left   = 0;
    bit          hold_done   = 1'b0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("section_block_framer_unit: mismatch");
            $finish;
        end
    end

    // Neither side idles while this stretch of the output goes by.
    function automatic bit burst_window();
        return beats_seen >= 350 && beats_seen < 650;
    endfunction

    function automatic int unsigned tail_offset(int unsigned len);
        return (len == 0) ? 0 : ((len - 1) / sbf_pkg::BLOCK_BYTES) * sbf_pkg::BLOCK_BYTES;
    endfunction

    function automatic int unsigned block_span(int unsigned len, int unsigned off);
        int unsigned rest;
        rest = (len > off) ? len - off : 0;
        return (rest < sbf_pkg::BLOCK_BYTES) ? rest : sbf_pkg::BLOCK_BYTES;
    endfunction

    function automatic void restart_section();
        taken         = 0;
        pair_xor      = 16'h0;
        low_half      = 8'h0;
        drain_pos     = 0;
        drain_pending = 1'b0;
    endfunction

    function automatic void due_beat(logic [7:0] value, logic fe, logic se);
        beats_due.push_back('{value, fe, se});
    endfunction

    function automatic void due_le(logic [31:0] value, int nbytes);
        for (int i = 0; i < nbytes; i++)
            due_beat(value[8*i +: 8], 1'b0, 1'b0);
    endfunction

    function automatic void due_frame_head(int unsigned hlen, logic [15:0] kind);
        for (int i = 0; i < 4; i++)
            due_beat(FRAME_TAG[31 - 8*i -: 8], 1'b0, 1'b0);
        due_le(hlen, 2);
        due_le({16'h0, kind}, 2);
    endfunction

    // Works out the framed bytes that one accepted request produces.
    function automatic void frame_request(logic cmd, logic [7:0] din);
        int unsigned last_off, last_n, idx, blk_off, blk_n, pos;
        bit          closing;
        last_off = tail_offset(sec_length);
        last_n   = block_span(sec_length, last_off);
        if (cmd == sbf_pkg::CMD_DRAIN) begin
            if (!drain_pending || drain_pos >= last_n || drain_pos >= sbf_pkg::BLOCK_BYTES) begin
                drain_pending = 1'b0;
                return;
            end
            closing = (drain_pos + 1 >= last_n);
            due_beat(tail_store[drain_pos], closing, closing);
            if (closing)
                drain_pending = 1'b0;
            else
                drain_pos = (drain_pos + 1) & 32'h3FF;
            return;
        end
        if (drain_pending || taken >= sec_length)
            return;
        idx     = taken;
        blk_off = (idx / sbf_pkg::BLOCK_BYTES) * sbf_pkg::BLOCK_BYTES;
        blk_n   = block_span(sec_length, blk_off);
        pos     = idx - blk_off;
        if (idx[0] == 1'b0)
            low_half = din;
        else
            pair_xor = pair_xor ^ {din, low_half};
        taken = (idx + 1) & 32'hFF_FFFF;
        if (blk_off == last_off) begin
            tail_store[pos] = din;
            if (idx + 1 == sec_length) begin
                due_frame_head(HDR_FINAL + blk_n, KIND_FINAL);
                due_beat(MARK_FINAL, 1'b0, 1'b0);
                due_le(sec_address, 4);
                due_le({16'h0, pair_xor}, 2);
                due_le(blk_off, 4);
                due_le(blk_n, 2);
                due_le(32'h0, 3);
                drain_pending = 1'b1;
                drain_pos     = 0;
            end
            return;
        end
        if (pos == 0) begin
            due_frame_head(HDR_BLOCK + blk_n, KIND_BLOCK);
            due_beat(MARK_BLOCK, 1'b0, 1'b0);
            due_le(sec_address, 4);
            due_le(blk_off, 4);
            due_le(blk_n, 2);
            due_beat(8'h00, 1'b0, 1'b0);
        end
        due_beat(din, pos + 1 == blk_n, 1'b0);
    endfunction

    // Request driver.
    always @(posedge aclk) begin
        request_t req;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                frame_request(s_tuser, s_tdata);
            if (!s_tvalid || s_tready) begin
                if (requests_waiting.size() != 0
                        && (burst_window() || $urandom_range(0, 99) >= 35)) begin
                    req = requests_waiting.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= req.cmd;
                    s_tdata  <= req.data;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic report_field(string what, logic [7:0] want, logic [7:0] got);
        errors++;
        $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
    endtask

    // Once, the receiver holds off long enough for the block to back up.
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && beats_seen >= 300) begin
            hold_done <= 1'b1;
            hold_left <= 400;
        end
    end

    // Result monitor.
    always @(posedge aclk) begin
        beat_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                beats_seen <= beats_seen + 1;
                if (beats_due.size() == 0) begin
                    errors++;
                    $display("%0t: byte expected none actual %0h", $time, m_tdata);
                end else begin
                    want = beats_due.pop_front();
                    if (m_tdata !== want.value)
                        report_field("out_byte", want.value, m_tdata);
                    if (m_tlast !== want.frame_end)
                        report_field("frame_end", {7'h0, want.frame_end}, {7'h0, m_tlast});
                    if (m_tuser !== want.section_end)
                        report_field("section_end", {7'h0, want.section_end},
                                     {7'h0, m_tuser});
                end
            end
            if (hold_left != 0)
                m_tready <= 1'b0;
            else
                m_tready <= burst_window() || $urandom_range(0, 99) >= 35;
        end
    end

    task automatic push_request(logic cmd, logic [7:0] data);
        requests_waiting.push_back('{cmd, data});
    endtask

    // Data bytes, with stray drain ticks mixed in that the block must ignore.
    task automatic push_data(int unsigned n, int noise_pct);
        for (int unsigned i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < noise_pct)
                push_request(sbf_pkg::CMD_DRAIN, 8'($urandom));
            push_request(sbf_pkg::CMD_DATA, 8'($urandom));
        end
    endtask

    // Drain ticks, with stray data bytes that arrive while the drain is pending.
    task automatic push_drains(int unsigned n, int noise_pct);
        for (int unsigned i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < noise_pct)
                push_request(sbf_pkg::CMD_DATA, 8'($urandom));
            push_request(sbf_pkg::CMD_DRAIN, 8'($urandom));
        end
    endtask

    task automatic write_register(logic idx, logic [31:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        if (idx == sbf_pkg::REG_ADDRESS)
            sec_address = value;
        else
            sec_length = {8'h0, value[23:0]};
        restart_section();
    endtask

    task automatic set_section(write_plan_t plan, logic [31:0] addr, logic [31:0] len_word);
        case (plan)
            WRITE_BOTH: begin
                write_register(sbf_pkg::REG_ADDRESS, addr);
                write_register(sbf_pkg::REG_LENGTH, len_word);
            end
            WRITE_LENGTH_FIRST: begin
                write_register(sbf_pkg::REG_LENGTH, len_word);
                write_register(sbf_pkg::REG_ADDRESS, addr);
            end
            WRITE_LENGTH_ONLY: begin
                write_register(sbf_pkg::REG_LENGTH, len_word);
            end
            default: begin
                write_register(sbf_pkg::REG_ADDRESS, addr);
            end
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Waits until every request is taken and every framed byte has come back.
    task automatic settle();
        do
            @(posedge aclk);
        while (requests_waiting.size() != 0 || s_tvalid || beats_due.size() != 0);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    initial begin
        int unsigned len, nd, nt, useful, r;
        logic [31:0] addr, len_word;
        write_plan_t plan;
        bit          whole;
        useful = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Out of reset the section is empty: nothing may come out.
        push_request(sbf_pkg::CMD_DATA, 8'h5A);
        push_request(sbf_pkg::CMD_DRAIN, 8'hA5);
        settle();

        // One-byte section, with bytes during the drain and past the end.
        set_section(WRITE_BOTH, 32'h0000_0000, 32'd1);
        push_request(sbf_pkg::CMD_DATA, 8'h00);
        push_request(sbf_pkg::CMD_DATA, 8'hFF);
        push_request(sbf_pkg::CMD_DRAIN, 8'h00);
        push_request(sbf_pkg::CMD_DRAIN, 8'hFF);
        push_request(sbf_pkg::CMD_DATA, 8'hAB);
        settle();

        set_section(WRITE_LENGTH_FIRST, 32'hFFFF_FFFF, 32'd2);
        push_request(sbf_pkg::CMD_DATA, 8'hFF);
        push_request(sbf_pkg::CMD_DATA, 8'hFF);
        push_drains(2, 0);
        settle();

        // Odd length leaves the trailing byte out of the checksum; upper write bits unused.
        set_section(WRITE_BOTH, 32'h1234_5678, 32'hFF00_0003);
        push_request(sbf_pkg::CMD_DATA, 8'h01);
        push_request(sbf_pkg::CMD_DATA, 8'h80);
        push_request(sbf_pkg::CMD_DATA, 8'h7F);
        push_drains(3, 0);
        settle();

        // Longest section: only the start of its first full block goes out.
        set_section(WRITE_BOTH, 32'hA5A5_A5A5, 32'h00FF_FFFF);
        push_data(10, 0);
        settle();

        // One full block, then a single-byte final block.
        set_section(WRITE_BOTH, $urandom, sbf_pkg::BLOCK_BYTES + 1);
        push_data(sbf_pkg::BLOCK_BYTES + 1, 0);
        push_drains(1, 0);
        settle();

        while (useful < RANDOM_GOAL) begin
            r = $urandom_range(0, 99);
            if (r < 8)
                len = 0;
            else if (r < 85)
                len = $urandom_range(1, 48);
            else
                len = $urandom_range(49, 96);
            r = $urandom_range(0, 99);
            if (r < 20)
                addr = 32'h0000_0000;
            else if (r < 40)
                addr = 32'hFFFF_FFFF;
            else
                addr = $urandom;
            len_word        = len;
            len_word[31:24] = 8'($urandom_range(0, 255));
            plan = write_plan_t'($urandom_range(0, 3));
            set_section(plan, addr, len_word);
            len = sec_length;

            whole = $urandom_range(0, 99) >= 10;
            nd = whole ? len : $urandom_range(0, len);
            push_data(nd, 5);
            nt = 0;
            if (whole && len != 0) begin
                nt = block_span(len, tail_offset(len));
                if ($urandom_range(0, 99) < 10)
                    nt = $urandom_range(0, nt);
            end
            push_drains(nt, 5);
            repeat ($urandom_range(0, 3))
                push_request(1'($urandom_range(0, 1)), 8'($urandom));
            useful += nd + nt;
            settle();
        end

        if (errors == 0)
            $display("section_block_framer_unit: match");
        else
            $display("section_block_framer_unit: mismatch");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
sv/sbf_pkg.sv
sv/sbf_ram.sv
sv/section_block_framer_unit.sv
test/tb_section_block_framer_unit.sv
